[design/circle_box_contact_macros.svh]
// Assertion macros for the circle_box_contact block.
`ifndef CIRCLE_BOX_CONTACT_MACROS_SVH
`define CIRCLE_BOX_CONTACT_MACROS_SVH

`ifndef ASSERT_OFF
`define CBC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CBC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CBC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[design/cbc_pkg.sv]
// Shared widths, side codes and types for the circle/box contact block.
`timescale 1ns / 1ps
package cbc_pkg;
  localparam int COORD_WIDTH  = 24;
  localparam int RADIUS_WIDTH = 23;
  localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
  localparam int SQ_WIDTH     = 2 * DIFF_WIDTH;
  localparam int RSQ_WIDTH    = 2 * RADIUS_WIDTH;
  localparam int HIT_WIDTH    = (SQ_WIDTH + 1 > RSQ_WIDTH) ? SQ_WIDTH + 1 : RSQ_WIDTH;
  localparam int CMP_WIDTH    = DIFF_WIDTH + RADIUS_WIDTH;

  typedef logic [2:0] side_t;

  localparam side_t SIDE_DOWN  = 3'd0;
  localparam side_t SIDE_RIGHT = 3'd1;
  localparam side_t SIDE_UP    = 3'd2;
  localparam side_t SIDE_LEFT  = 3'd3;
  localparam side_t SIDE_NONE  = 3'd4;
endpackage

[design/cbc_pick_side.sv]
// Contact side selection: first strictly largest positive component of (+y, +x, -y, -x).
`timescale 1ns / 1ps
module cbc_pick_side (
  input  logic signed [cbc_pkg::DIFF_WIDTH-1:0] dir_x,
  input  logic signed [cbc_pkg::DIFF_WIDTH-1:0] dir_y,
  output cbc_pkg::side_t                        side
);
  import cbc_pkg::*;

  logic                  x_zero;
  logic                  y_zero;
  logic [DIFF_WIDTH-1:0] mag_x;
  logic [DIFF_WIDTH-1:0] mag_y;
  side_t                 vert_side;
  side_t                 horz_side;

  assign x_zero    = (dir_x == '0);
  assign y_zero    = (dir_y == '0);
  assign mag_x     = dir_x[DIFF_WIDTH-1] ? $unsigned(-dir_x) : $unsigned(dir_x);
  assign mag_y     = dir_y[DIFF_WIDTH-1] ? $unsigned(-dir_y) : $unsigned(dir_y);
  assign vert_side = dir_y[DIFF_WIDTH-1] ? SIDE_UP : SIDE_DOWN;
  assign horz_side = dir_x[DIFF_WIDTH-1] ? SIDE_LEFT : SIDE_RIGHT;

  always_comb begin
    priority if (x_zero && y_zero) begin
      side = SIDE_NONE;
    end else if (y_zero) begin
      side = horz_side;
    end else if (x_zero) begin
      side = vert_side;
    end else if (mag_y > mag_x) begin
      side = vert_side;
    end else if (mag_x > mag_y) begin
      side = horz_side;
    end else begin
      // tie: lower code wins
      side = (vert_side < horz_side) ? vert_side : horz_side;
    end
  end
endmodule

[design/circle_box_contact.sv]
// Top level of the circle versus axis-aligned box contact test.
// One circle/box pair is taken per beat and one result (hit, contact side,
// penetration) comes out per beat, in order, from the output register.
// The pipeline has four register stages: clamp and offset, squaring (two
// 25x25 multipliers and one 23x23), hit compare and side pick, penetration.
// It sustains one item per clock; in_ready drops only while the output
// register holds a result that is not taken and every stage behind it is full.
`timescale 1ns / 1ps
`include "circle_box_contact_macros.svh"
module circle_box_contact (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cbc_pkg::COORD_WIDTH-1:0] center_x,
  input  logic signed [cbc_pkg::COORD_WIDTH-1:0] center_y,
  input  logic        [cbc_pkg::RADIUS_WIDTH-1:0] circle_radius,
  input  logic signed [cbc_pkg::COORD_WIDTH-1:0] vel_x,
  input  logic signed [cbc_pkg::COORD_WIDTH-1:0] vel_y,
  input  logic signed [cbc_pkg::COORD_WIDTH-1:0] box_min_x,
  input  logic signed [cbc_pkg::COORD_WIDTH-1:0] box_min_y,
  input  logic signed [cbc_pkg::COORD_WIDTH-1:0] box_max_x,
  input  logic signed [cbc_pkg::COORD_WIDTH-1:0] box_max_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   hit,
  output cbc_pkg::side_t                         contact_side,
  output logic        [cbc_pkg::RADIUS_WIDTH-1:0] penetration
);
  import cbc_pkg::*;

  // stage handshake
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1: clamp center into box, form offset
  logic signed [COORD_WIDTH-1:0]  clo_x, clo_y, cl_x, cl_y;
  logic signed [DIFF_WIDTH-1:0]   dx_next, dy_next;
  logic signed [DIFF_WIDTH-1:0]   s1_dx, s1_dy;
  logic signed [COORD_WIDTH-1:0]  s1_vx, s1_vy;
  logic        [RADIUS_WIDTH-1:0] s1_r;

  assign clo_x   = (center_x < box_min_x) ? box_min_x : center_x;
  assign clo_y   = (center_y < box_min_y) ? box_min_y : center_y;
  assign cl_x    = (clo_x > box_max_x) ? box_max_x : clo_x;
  assign cl_y    = (clo_y > box_max_y) ? box_max_y : clo_y;
  assign dx_next = DIFF_WIDTH'(center_x) - DIFF_WIDTH'(cl_x);
  assign dy_next = DIFF_WIDTH'(center_y) - DIFF_WIDTH'(cl_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_dx <= dx_next;
      s1_dy <= dy_next;
      s1_vx <= vel_x;
      s1_vy <= vel_y;
      s1_r  <= circle_radius;
    end
  end

  // stage 2: squares, absolute offsets, direction vector
  logic signed [SQ_WIDTH-1:0]     sqx_next, sqy_next;
  logic        [RSQ_WIDTH-1:0]    rsq_next;
  logic                           inside_next;
  logic signed [DIFF_WIDTH-1:0]   dirx_next, diry_next;
  logic        [SQ_WIDTH-1:0]     s2_sqx, s2_sqy;
  logic        [RSQ_WIDTH-1:0]    s2_rsq;
  logic        [DIFF_WIDTH-1:0]   s2_adx, s2_ady;
  logic signed [DIFF_WIDTH-1:0]   s2_dirx, s2_diry;
  logic                           s2_inside;
  logic        [RADIUS_WIDTH-1:0] s2_r;

  assign sqx_next    = s1_dx * s1_dx;
  assign sqy_next    = s1_dy * s1_dy;
  assign rsq_next    = RSQ_WIDTH'(s1_r) * RSQ_WIDTH'(s1_r);
  assign inside_next = (s1_dx == '0) && (s1_dy == '0);
  // inside the box: direction comes from the reversed velocity
  assign dirx_next   = inside_next ? -DIFF_WIDTH'(s1_vx) : s1_dx;
  assign diry_next   = inside_next ? -DIFF_WIDTH'(s1_vy) : s1_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_sqx    <= $unsigned(sqx_next);
      s2_sqy    <= $unsigned(sqy_next);
      s2_rsq    <= rsq_next;
      s2_adx    <= s1_dx[DIFF_WIDTH-1] ? $unsigned(-s1_dx) : $unsigned(s1_dx);
      s2_ady    <= s1_dy[DIFF_WIDTH-1] ? $unsigned(-s1_dy) : $unsigned(s1_dy);
      s2_dirx   <= dirx_next;
      s2_diry   <= diry_next;
      s2_inside <= inside_next;
      s2_r      <= s1_r;
    end
  end

  // stage 3: hit test and side pick
  logic                           in_range;
  logic [HIT_WIDTH-1:0]           dist_sq;
  logic                           hit_next;
  side_t                          dir_side;
  side_t                          side_next;
  logic                           s3_hit;
  side_t                          s3_side;
  logic [RADIUS_WIDTH-1:0]        s3_adx, s3_ady, s3_r;

  cbc_pick_side u_pick_side (
    .dir_x (s2_dirx),
    .dir_y (s2_diry),
    .side  (dir_side)
  );

  assign in_range  = (CMP_WIDTH'(s2_adx) <= CMP_WIDTH'(s2_r)) &&
                     (CMP_WIDTH'(s2_ady) <= CMP_WIDTH'(s2_r));
  assign dist_sq   = HIT_WIDTH'(s2_sqx) + HIT_WIDTH'(s2_sqy);
  assign hit_next  = in_range && (dist_sq <= HIT_WIDTH'(s2_rsq));
  assign side_next = (!hit_next || (s2_inside && (s2_r == '0))) ? SIDE_NONE : dir_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_hit  <= hit_next;
      s3_side <= side_next;
      // on a hit both offsets are at most the radius
      s3_adx  <= RADIUS_WIDTH'(s2_adx);
      s3_ady  <= RADIUS_WIDTH'(s2_ady);
      s3_r    <= s2_r;
    end
  end

  // stage 4: penetration along the chosen axis
  logic [RADIUS_WIDTH-1:0] pen_next;

  always_comb begin
    unique case (s3_side)
      SIDE_DOWN, SIDE_UP:    pen_next = s3_r - s3_ady;
      SIDE_RIGHT, SIDE_LEFT: pen_next = s3_r - s3_adx;
      default:               pen_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      hit          <= s3_hit;
      contact_side <= s3_side;
      penetration  <= pen_next;
    end
  end

  `CBC_ASSERT_IMPLY(a_miss_clean, clk, rst, out_valid && !hit,
                    (contact_side == SIDE_NONE) && (penetration == '0))
  `CBC_ASSERT_IMPLY(a_none_no_pen, clk, rst, out_valid && (contact_side == SIDE_NONE),
                    penetration == '0)
  `CBC_ASSERT_IMPLY(a_stall_from_out, clk, rst, !in_ready,
                    out_valid && !out_ready && v1 && v2 && v3)
  `CBC_ASSERT_NEXT(a_stage3_moves, clk, rst, v3 && rdy4, out_valid)
endmodule

[sim/circle_box_contact_tb.sv]
// Self-checking testbench for circle_box_contact: predicted contacts vs. pipeline output.
`timescale 1ns / 1ps
module circle_box_contact_tb;
  import cbc_pkg::*;

  localparam int RANDOM_PAIRS = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 12;
  localparam int MIN_COORD    = -8388608;
  localparam int MAX_COORD    = 8388607;
  localparam int MAX_RADIUS   = 8388607;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic [RADIUS_WIDTH-1:0]       radius;
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
    bit                            drain_first;
  } shape_pair_t;

  typedef struct {
    logic                    hit;
    side_t                   side;
    logic [RADIUS_WIDTH-1:0] depth;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_WIDTH-1:0] center_x = '0;
  logic signed [COORD_WIDTH-1:0] center_y = '0;
  logic [RADIUS_WIDTH-1:0]       circle_radius = '0;
  logic signed [COORD_WIDTH-1:0] vel_x = '0;
  logic signed [COORD_WIDTH-1:0] vel_y = '0;
  logic signed [COORD_WIDTH-1:0] box_min_x = '0;
  logic signed [COORD_WIDTH-1:0] box_min_y = '0;
  logic signed [COORD_WIDTH-1:0] box_max_x = '0;
  logic signed [COORD_WIDTH-1:0] box_max_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  side_t contact_side;
  logic [RADIUS_WIDTH-1:0] penetration;

  shape_pair_t pending_pairs[$];
  contact_t    expected_contacts[$];
  shape_pair_t offered_pair;
  int          mismatch_count = 0;
  int          accepted_pairs = 0;
  int          result_index = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          holdoff_left = 0;
  bit          holdoff_done = 0;
  bit [15:0]   stall_cycle = '0;
  int          idle_cycles = 0;

  circle_box_contact u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .center_x      (center_x),
    .center_y      (center_y),
    .circle_radius (circle_radius),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .box_min_x     (box_min_x),
    .box_min_y     (box_min_y),
    .box_max_x     (box_max_x),
    .box_max_y     (box_max_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .contact_side  (contact_side),
    .penetration   (penetration)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // First strictly largest positive component among +y, +x, -y, -x.
  function automatic side_t leading_side(longint x, longint y);
    side_t  s;
    longint best;
    s = SIDE_NONE;
    best = 0;
    if (y > best) begin best = y; s = SIDE_DOWN; end
    if (x > best) begin best = x; s = SIDE_RIGHT; end
    if (-y > best) begin best = -y; s = SIDE_UP; end
    if (-x > best) begin best = -x; s = SIDE_LEFT; end
    return s;
  endfunction

  function automatic contact_t predict_contact(shape_pair_t p);
    contact_t res;
    longint   cx, cy, r, near_x, near_y, dx, dy, adx, ady;
    cx = p.cx;
    cy = p.cy;
    r = p.radius;
    // clamp raises to min first, then lowers to max (inverted box lands on max)
    near_x = (cx < longint'(p.min_x)) ? longint'(p.min_x) : cx;
    near_x = (near_x > longint'(p.max_x)) ? longint'(p.max_x) : near_x;
    near_y = (cy < longint'(p.min_y)) ? longint'(p.min_y) : cy;
    near_y = (near_y > longint'(p.max_y)) ? longint'(p.max_y) : near_y;
    dx = cx - near_x;
    dy = cy - near_y;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    res.hit = 1'b0;
    res.side = SIDE_NONE;
    res.depth = '0;
    if (adx <= r && ady <= r && dx * dx + dy * dy <= r * r) begin
      res.hit = 1'b1;
      if (dx == 0 && dy == 0) begin
        // center inside: direction comes from the reversed velocity
        if (r > 0) res.side = leading_side(-longint'(p.vx), -longint'(p.vy));
      end else begin
        res.side = leading_side(dx, dy);
      end
      case (res.side)
        SIDE_DOWN, SIDE_UP:    res.depth = RADIUS_WIDTH'(r - ady);
        SIDE_RIGHT, SIDE_LEFT: res.depth = RADIUS_WIDTH'(r - adx);
        default:               res.depth = '0;
      endcase
    end
    return res;
  endfunction

  function automatic shape_pair_t make_pair(int cx, int cy, int r, int vx, int vy,
                                            int mnx, int mny, int mxx, int mxy);
    shape_pair_t p;
    p.cx = COORD_WIDTH'(cx);
    p.cy = COORD_WIDTH'(cy);
    p.radius = RADIUS_WIDTH'(r);
    p.vx = COORD_WIDTH'(vx);
    p.vy = COORD_WIDTH'(vy);
    p.min_x = COORD_WIDTH'(mnx);
    p.min_y = COORD_WIDTH'(mny);
    p.max_x = COORD_WIDTH'(mxx);
    p.max_y = COORD_WIDTH'(mxy);
    p.drain_first = 1'b0;
    return p;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 5))
      0: return MIN_COORD;
      1: return MAX_COORD;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int pick_radius_extreme();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return MAX_RADIUS;
      2: return 1;
      default: return int'($urandom_range(0, MAX_RADIUS));
    endcase
  endfunction

  function automatic int random_velocity();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return int'($urandom_range(0, 512)) - 256;
      2: return pick_extreme();
      default: return int'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH result %0d: %s", result_index, what);
    mismatch_count++;
  endtask

  // Stimulus
  initial begin
    shape_pair_t p;
    int          scale, bx, by, w, h;
    // unit box 10.0 x 10.0 at the origin for the directed pairs
    pending_pairs.push_back(make_pair(1280, 2660, 256, 0, 0, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(2660, 1280, 256, 0, 0, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(1280, -100, 256, 0, 0, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(-100, 1280, 256, 0, 0, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(1280, 3000, 256, 5, 5, 0, 0, 2560, 2560));
    // exact touch at a corner, then the same just short of it
    pending_pairs.push_back(make_pair(2713, 2764, 255, 0, 0, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(2713, 2764, 254, 0, 0, 0, 0, 2560, 2560));
    // diagonal tie picks down
    pending_pairs.push_back(make_pair(2660, 2660, 256, 0, 0, 0, 0, 2560, 2560));
    // center inside: side from reversed velocity
    pending_pairs.push_back(make_pair(1280, 1280, 300, 0, -5, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(1280, 1280, 300, -7, 0, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(1280, 1280, 300, 0, 9, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(1280, 1280, 300, 3, 0, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(1280, 1280, 300, -4, -4, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(1280, 1280, 300, 0, 0, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(1280, 1280, 0, -3, 8, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(2560, 1280, 0, 0, 0, 0, 0, 2560, 2560));
    pending_pairs.push_back(make_pair(2561, 1280, 0, 0, 0, 0, 0, 2560, 2560));
    // inverted box on x: closest point is max
    pending_pairs.push_back(make_pair(1280, 1280, 2000, 0, 0, 2560, 0, 0, 2560));
    pending_pairs.push_back(make_pair(MAX_COORD, MAX_COORD, MAX_RADIUS, MAX_COORD, MIN_COORD,
                                      MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD));
    pending_pairs.push_back(make_pair(MIN_COORD, MIN_COORD, MAX_RADIUS, MIN_COORD, MAX_COORD,
                                      MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD));
    pending_pairs.push_back(make_pair(0, 0, MAX_RADIUS, MAX_COORD, MIN_COORD,
                                      MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD));
    pending_pairs.push_back(make_pair(MAX_COORD, 0, MAX_RADIUS, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, MIN_COORD + 1, MAX_RADIUS, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      case ($urandom_range(0, 3))
        0: scale = 64;
        1: scale = 4096;
        2: scale = 1 << 18;
        default: scale = 1 << 22;
      endcase
      bx = int'($urandom_range(0, MAX_COORD)) - 4194304;
      by = int'($urandom_range(0, MAX_COORD)) - 4194304;
      w = int'($urandom_range(0, scale));
      h = int'($urandom_range(0, scale));
      case ($urandom_range(0, 9))
        6: p = make_pair(bx + int'($urandom_range(0, w)), by + int'($urandom_range(0, h)),
                         int'($urandom_range(0, scale)), random_velocity(), random_velocity(),
                         bx, by, bx + w, by + h);
        7: p = make_pair(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                         int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                         int'($urandom));
        8: p = make_pair(bx + int'($urandom_range(0, w + 2 * scale)) - scale,
                         by + int'($urandom_range(0, h + 2 * scale)) - scale,
                         int'($urandom_range(0, scale)), random_velocity(), random_velocity(),
                         bx + w, by + h, bx, by);
        9: p = make_pair(pick_extreme(), pick_extreme(), pick_radius_extreme(),
                         pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                         pick_extreme(), pick_extreme());
        default: p = make_pair(bx + int'($urandom_range(0, w + 2 * scale)) - scale,
                               by + int'($urandom_range(0, h + 2 * scale)) - scale,
                               int'($urandom_range(0, scale)), random_velocity(),
                               random_velocity(), bx, by, bx + w, by + h);
      endcase
      // hold this beat back until the pipeline has emptied
      p.drain_first = (i == 250);
      pending_pairs.push_back(p);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || in_valid) @(posedge clk);
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Sender: bursts of beats with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_contacts.push_back(predict_contact(offered_pair));
        accepted_pairs++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() == 0 ||
                     (pending_pairs[0].drain_first && expected_contacts.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          offered_pair = pending_pairs.pop_front();
          in_valid      <= 1'b1;
          center_x      <= offered_pair.cx;
          center_y      <= offered_pair.cy;
          circle_radius <= offered_pair.radius;
          vel_x         <= offered_pair.vx;
          vel_y         <= offered_pair.vy;
          box_min_x     <= offered_pair.min_x;
          box_min_y     <= offered_pair.min_y;
          box_max_x     <= offered_pair.max_x;
          box_max_y     <= offered_pair.max_y;
          if (burst_left == 0) begin
            burst_left = int'($urandom_range(1, 24));
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: stall pattern picked by bits [8:6] of a free-running counter, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      stall_cycle++;
      if (!holdoff_done && accepted_pairs >= 120) begin
        holdoff_done = 1'b1;
        holdoff_left = 80;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_cycle[8:6])
          3'd0, 3'd4: out_ready <= 1'b1;
          3'd1:       out_ready <= 1'($urandom_range(0, 1));
          3'd2:       out_ready <= ($urandom_range(0, 3) == 0);
          3'd3:       out_ready <= (stall_cycle[1:0] != 2'b11);
          3'd5:       out_ready <= stall_cycle[2];
          default:    out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    contact_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_contacts.size() == 0) begin
        report_mismatch("result with no pending input");
      end else begin
        want = expected_contacts.pop_front();
        if (hit !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
        if (contact_side !== want.side)
          report_mismatch($sformatf("side %0d, want %0d", contact_side, want.side));
        if (penetration !== want.depth)
          report_mismatch($sformatf("penetration %0d, want %0d", penetration, want.depth));
      end
      result_index++;
    end
  end

  // Watchdog: cycles without any beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[files.f]
+incdir+design
design/cbc_pkg.sv
design/cbc_pick_side.sv
design/circle_box_contact.sv
sim/circle_box_contact_tb.sv
